// File: src/mavg_pkg.sv
`timescale 1ns / 1ps
package mavg_pkg;

  // Default sizing of the filter
  localparam int DEF_MAX_WINDOW  = 32;
  localparam int DEF_SAMPLE_BITS = 16;

  // Window length register and fill count width
  localparam int LEN_W        = 6;
  localparam int RESET_WINDOW = 5;

  // Configuration port
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] RegWindow = '0;

  // Item opcodes
  localparam logic OpPush  = 1'b0;
  localparam logic OpClear = 1'b1;

endpackage

// File: src/mavg_if.sv
`timescale 1ns / 1ps
interface mavg_in_if #(
  parameter int SAMPLE_BITS = mavg_pkg::DEF_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, opcode, sample, input ready);
  modport sink (input valid, opcode, sample, output ready);
endinterface

interface mavg_out_if #(
  parameter int SAMPLE_BITS = mavg_pkg::DEF_SAMPLE_BITS
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_BITS-1:0]  average;
  logic [mavg_pkg::LEN_W-1:0]     fill_count;

  modport source (output valid, average, fill_count, input ready);
  modport sink (input valid, average, fill_count, output ready);
endinterface

// File: src/mavg_ring.sv
`timescale 1ns / 1ps
module mavg_ring #(
  parameter int DEPTH  = mavg_pkg::DEF_MAX_WINDOW,
  parameter int WIDTH  = mavg_pkg::DEF_SAMPLE_BITS,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [ADDR_W-1:0]       waddr_i,
  input  logic signed [WIDTH-1:0] wdata_i,
  input  logic [ADDR_W-1:0]       raddr_i,
  output logic signed [WIDTH-1:0] rdata_o
);
  logic signed [WIDTH-1:0] mem_q [DEPTH];
  logic signed [WIDTH-1:0] rdata_q;

  // Write one slot per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read of the addressed slot
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// File: src/mavg_div.sv
`timescale 1ns / 1ps
module mavg_div #(
  parameter int SUM_W = 21
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [SUM_W-1:0]       dividend_i,
  input  logic [mavg_pkg::LEN_W-1:0]    divisor_i,
  output logic                          busy_o,
  output logic signed [SUM_W-1:0]       quotient_o
);
  import mavg_pkg::*;

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]  quo_q, quo_d;
  logic [LEN_W-1:0]  rem_q, rem_d;
  logic [LEN_W-1:0]  dvs_q, dvs_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              neg_q, neg_d;
  logic              busy_q, busy_d;
  logic [SUM_W-1:0]  mag;
  logic [LEN_W:0]    shifted;
  logic [LEN_W:0]    trial;
  logic              fits;

  // Magnitude of the dividend; the most negative value wraps to itself as unsigned
  assign mag = dividend_i[SUM_W-1] ? SUM_W'(-dividend_i) : SUM_W'(dividend_i);

  // One restoring step: bring down the next dividend bit and try the subtract
  assign shifted = {rem_q, quo_q[SUM_W-1]};
  assign fits    = (shifted >= {1'b0, dvs_q});
  assign trial   = shifted - {1'b0, dvs_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    step_d = step_q;
    neg_d  = neg_q;
    busy_d = busy_q;
    if (start_i) begin
      quo_d  = mag;
      rem_d  = '0;
      dvs_d  = divisor_i;
      neg_d  = dividend_i[SUM_W-1];
      step_d = STEP_W'(SUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d  = {quo_q[SUM_W-2:0], fits};
      rem_d  = fits ? trial[LEN_W-1:0] : shifted[LEN_W-1:0];
      step_d = step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  // Control flops
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  // Datapath flops
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  // Restore the sign: truncation toward zero
  assign quotient_o = neg_q ? -$signed(quo_q) : $signed(quo_q);
  assign busy_o     = busy_q;
endmodule

// File: src/moving_average_filter_core.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake            Payload
// in_i      in   valid / ready        opcode, sample
// out_o     out  valid / ready        average, fill_count
// apb       in   psel/penable/pready  paddr, pwdata -> window_length, prdata
//
// A push runs from input transfer through a ring read, a sum update and the
// divider start to the divide, which retires one quotient bit per cycle; the
// input is free again once the result is captured. A clear completes in idle.
// Reset leaves window_length at 5 and the history empty; the ring is not swept.
// The input stays ready while a result waits in the output register; a newer
// quotient waits in the divider until that register frees.
module moving_average_filter_core #(
  parameter int MAX_WINDOW  = mavg_pkg::DEF_MAX_WINDOW,
  parameter int SAMPLE_BITS = mavg_pkg::DEF_SAMPLE_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  mavg_in_if.sink                           in_i,
  mavg_out_if.source                        out_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mavg_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [mavg_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [mavg_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import mavg_pkg::*;

  localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW);
  localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CMP_W = (PTR_W > LEN_W) ? PTR_W : LEN_W;
  localparam int LEN_MAX = (1 << LEN_W) - 1;
  localparam logic [LEN_W-1:0] WinCap =
    LEN_W'((MAX_WINDOW > LEN_MAX) ? LEN_MAX : MAX_WINDOW);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_UPD   = 5'b00100,
    S_START = 5'b01000,
    S_DIV   = 5'b10000
  } state_e;

  state_e                  state_q, state_d;
  logic [LEN_W-1:0]        window_q, window_d;
  logic [PTR_W-1:0]        wpos_q, wpos_d;
  logic [LEN_W-1:0]        held_q, held_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [PTR_W-1:0]        slot_q, slot_d;
  logic                    full_q, full_d;
  logic signed [SAMPLE_BITS-1:0] sample_q, sample_d;
  logic                    out_valid_q, out_valid_d;
  logic signed [SAMPLE_BITS-1:0] avg_q, avg_d;
  logic [LEN_W-1:0]        fill_q, fill_d;

  logic [LEN_W-1:0]        win;
  logic [PTR_W-1:0]        slot;
  logic [CMP_W:0]          next_pos;
  logic [REG_IDX_W-1:0]    reg_idx;
  logic                    cfg_we;
  logic                    in_xfer;
  logic                    capture;
  logic                    ring_we;
  logic signed [SAMPLE_BITS-1:0] old_sample;
  logic                    div_start;
  logic                    div_busy;
  logic signed [SUM_W-1:0] quotient;

  // Register access
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign cfg_we  = psel && penable && pwrite && (reg_idx == RegWindow);
  assign pready  = 1'b1;
  assign prdata  = (reg_idx == RegWindow) ? APB_DATA_W'(window_q) : '0;

  // Effective window: zero acts as one, clamp to the ring depth
  always_comb begin
    if (window_q == '0) begin
      win = LEN_W'(1);
    end else if (window_q > WinCap) begin
      win = WinCap;
    end else begin
      win = window_q;
    end
  end

  // Slot for the incoming sample and the one after it
  assign slot     = (CMP_W'(wpos_q) >= CMP_W'(win)) ? '0 : wpos_q;
  assign next_pos = (CMP_W + 1)'(slot_q) + (CMP_W + 1)'(1);

  assign in_xfer   = in_i.valid && in_i.ready;
  assign capture   = (state_q == S_DIV) && !div_busy && (!out_valid_q || out_o.ready);
  assign ring_we   = (state_q == S_UPD);
  assign div_start = (state_q == S_START);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    window_d    = window_q;
    wpos_d      = wpos_q;
    held_d      = held_q;
    sum_d       = sum_q;
    slot_d      = slot_q;
    full_d      = full_q;
    sample_d    = sample_q;
    out_valid_d = out_valid_q && !out_o.ready;
    avg_d       = avg_q;
    fill_d      = fill_q;

    case (state_q)
      S_IDLE: begin
        if (cfg_we) begin
          window_d = pwdata[LEN_W-1:0];
          wpos_d   = '0;
          held_d   = '0;
          sum_d    = '0;
        end
        if (in_xfer) begin
          if (in_i.opcode == OpClear) begin
            wpos_d = '0;
            held_d = '0;
            sum_d  = '0;
          end else begin
            slot_d   = slot;
            full_d   = (held_q >= win);
            sample_d = in_i.sample;
            state_d  = S_READ;
          end
        end
      end
      S_READ: begin
        state_d = S_UPD;
      end
      S_UPD: begin
        // Drop the oldest sample once full, add the new one, advance the slot
        sum_d  = sum_q - (full_q ? SUM_W'(old_sample) : '0) + SUM_W'(sample_q);
        held_d = full_q ? win : held_q + LEN_W'(1);
        wpos_d = (next_pos >= (CMP_W + 1)'(win)) ? '0 : next_pos[PTR_W-1:0];
        state_d = S_START;
      end
      S_START: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        if (capture) begin
          out_valid_d = 1'b1;
          avg_d       = quotient[SAMPLE_BITS-1:0];
          fill_d      = held_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control flops
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      window_q    <= LEN_W'(RESET_WINDOW);
      wpos_q      <= '0;
      held_q      <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      window_q    <= window_d;
      wpos_q      <= wpos_d;
      held_q      <= held_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Item and result flops
  always_ff @(posedge clk_i) begin
    slot_q   <= slot_d;
    full_q   <= full_d;
    sample_q <= sample_d;
    avg_q    <= avg_d;
    fill_q   <= fill_d;
  end

  mavg_ring #(
    .DEPTH  (MAX_WINDOW),
    .WIDTH  (SAMPLE_BITS),
    .ADDR_W (PTR_W)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (slot_q),
    .wdata_i (sample_q),
    .raddr_i (slot_q),
    .rdata_o (old_sample)
  );

  mavg_div #(
    .SUM_W (SUM_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (held_q),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  assign in_i.ready       = (state_q == S_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.average    = avg_q;
  assign out_o.fill_count = fill_q;

  // Fill count never runs past the effective window
  a_held_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= win)
    else $error("fill count exceeds window");

  // Write position stays inside the effective window
  a_pos_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(wpos_q) < CMP_W'(win))
    else $error("write position outside window");

  // Divider is only started when idle
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  // A capture leaves the result valid and the sequencer idle
  a_capture_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    capture |=> out_valid_q && (state_q == S_IDLE))
    else $error("result capture did not complete");
endmodule
